// ===== sv/ppm_header_parse_row_framer_core_assert.svh =====
// Assertion helpers shared by the framer modules.
// Every assertion is clocked on clk_i and is switched off while rst_ni is low.
`ifndef PPM_HEADER_PARSE_ROW_FRAMER_CORE_ASSERT_SVH
`define PPM_HEADER_PARSE_ROW_FRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PPMHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define PPMHP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define PPMHP_ASSERT(label, prop, msg)
`define PPMHP_NEVER(label, cond, msg)
`endif

`endif

// ===== sv/ppmhp_pkg.sv =====
package ppmhp_pkg;

  // Sizing
  localparam int unsigned DimBits    = 32;
  localparam int unsigned TokenLimit = 64;
  localparam int unsigned TokLenW    = $clog2(TokenLimit);
  localparam int unsigned ProdW      = DimBits + 4;
  localparam int unsigned ColW       = DimBits + 2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // Characters of interest
  localparam logic [7:0] MagicFirst  = 8'h50;  // 'P'
  localparam logic [7:0] MagicSecond = 8'h36;  // '6'
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharPlus    = 8'h2b;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharLf      = 8'h0a;
  localparam logic [7:0] CharVt      = 8'h0b;
  localparam logic [7:0] CharFf      = 8'h0c;
  localparam logic [7:0] CharCr      = 8'h0d;

  localparam logic [DimBits-1:0] MaxvalOnly = DimBits'(255);

  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindFilter = 2'd1,
    KindPixel  = 2'd2,
    KindError  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrMagic    = 3'd0,
    ErrWidth    = 3'd1,
    ErrHeight   = 3'd2,
    ErrMaxval   = 3'd3,
    ErrTooLong  = 3'd4,
    ErrTooLarge = 3'd5,
    ErrShort    = 3'd6
  } err_e;

  // Work handed from the parser to the emitter
  typedef enum logic [2:0] {
    OpPixel       = 3'd0,  // pixel byte
    OpPixelRow    = 3'd1,  // filter byte, then pixel byte
    OpError       = 3'd2,  // error word
    OpHeader      = 3'd3,  // header accepted
    OpHeaderShort = 3'd4   // header accepted, then short data error
  } op_e;

  typedef enum logic {
    CfgMaxWidth  = 1'b0,
    CfgMaxHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         data;
    err_e               code;
    logic               last;
    logic [DimBits-1:0] width;
    logic [DimBits-1:0] height;
  } cmd_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CharSpace) || (b == CharTab) || (b == CharLf) ||
           (b == CharVt) || (b == CharFf) || (b == CharCr);
  endfunction

endpackage

// ===== sv/ppmhp_if.sv =====
// Input byte channel
interface ppmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

// Result channel
interface ppmhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] width_out;
  logic [31:0] height_out;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output out_byte, output width_out,
                  output height_out, output error_code, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input width_out,
                  input height_out, input error_code, input last, output ready);
endinterface

// Register write channel
interface ppmhp_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ppmhp_front.sv =====
`include "ppm_header_parse_row_framer_core_assert.svh"

module ppmhp_front import ppmhp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ppmhp_in_if.sink     in_i,
  ppmhp_cfg_if.sink    cfg_i,
  input  logic         full_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    PhMagic  = 7'b0000001,
    PhWidth  = 7'b0000010,
    PhHeight = 7'b0000100,
    PhMaxval = 7'b0001000,
    PhPixels = 7'b0010000,
    PhDone   = 7'b0100000,
    PhError  = 7'b1000000
  } phase_e;

  function automatic err_e phase_err(input phase_e p);
    unique case (p)
      PhWidth:  return ErrWidth;
      PhHeight: return ErrHeight;
      PhMaxval: return ErrMaxval;
      default:  return ErrMagic;
    endcase
  endfunction

  phase_e              phase_q, phase_d;
  logic                in_comment_q, in_comment_d;
  logic                in_token_q, in_token_d;
  logic [TokLenW-1:0]  tok_len_q, tok_len_d;
  logic [DimBits-1:0]  tok_val_q, tok_val_d;
  logic                tok_bad_q, tok_bad_d;
  logic                tok_digit_q, tok_digit_d;
  logic [DimBits-1:0]  img_w_q, img_w_d;
  logic [DimBits-1:0]  img_h_q, img_h_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [ColW-1:0]     row_last_q, row_last_d;
  logic [DimBits-1:0]  row_q, row_d;
  logic [31:0]         max_w_q, max_h_q;

  logic       in_hs;
  logic [7:0] b;
  logic       in_header;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign in_hs       = in_i.valid && in_i.ready;
  assign b           = in_i.in_byte;
  assign in_header   = (phase_q == PhMagic) || (phase_q == PhWidth) ||
                       (phase_q == PhHeight) || (phase_q == PhMaxval);

  // Verdict on the token held so far, should it close now
  logic   num_ok, close_fail, close_hdr;
  err_e   close_code;
  phase_e close_next;

  assign num_ok = !tok_bad_q && tok_digit_q;

  always_comb begin
    close_fail = 1'b0;
    close_hdr  = 1'b0;
    close_code = ErrMagic;
    close_next = phase_q;
    unique case (phase_q)
      PhMagic: begin
        close_fail = tok_bad_q || (tok_len_q != TokLenW'(2));
        close_code = ErrMagic;
        close_next = PhWidth;
      end
      PhWidth: begin
        close_fail = !num_ok || (tok_val_q == '0);
        close_code = ErrWidth;
        close_next = PhHeight;
      end
      PhHeight: begin
        close_fail = !num_ok || (tok_val_q == '0);
        close_code = ErrHeight;
        close_next = PhMaxval;
      end
      PhMaxval: begin
        close_next = PhPixels;
        if (!num_ok || (tok_val_q != MaxvalOnly)) begin
          close_fail = 1'b1;
          close_code = ErrMaxval;
        end else if ((32'(img_w_q) > max_w_q) || (32'(img_h_q) > max_h_q)) begin
          close_fail = 1'b1;
          close_code = ErrTooLarge;
        end else begin
          close_hdr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Token character: running length, value and validity
  logic [TokLenW-1:0] cur_len;
  logic [DimBits-1:0] cur_val;
  logic               cur_bad, cur_digit;
  logic               too_long, is_digit, magic_bad, ovf;
  logic [3:0]         dig_val;
  logic [ProdW-1:0]   prod;

  assign cur_len   = in_token_q ? tok_len_q : '0;
  assign cur_val   = in_token_q ? tok_val_q : '0;
  assign cur_bad   = in_token_q && tok_bad_q;
  assign cur_digit = in_token_q && tok_digit_q;
  assign too_long  = ({1'b0, cur_len} + 1'b1) >= (TokLenW + 1)'(TokenLimit);
  assign is_digit  = (b >= CharZero) && (b <= CharNine);
  assign dig_val   = 4'(b - CharZero);
  // value * 10 + digit as (value << 3) + (value << 1) + digit
  assign prod      = ProdW'({cur_val, 3'b000}) + ProdW'({cur_val, 1'b0}) + ProdW'(dig_val);
  assign ovf       = |prod[ProdW-1:DimBits];
  assign magic_bad = ((cur_len == '0) && (b != MagicFirst)) ||
                     ((cur_len == TokLenW'(1)) && (b != MagicSecond)) ||
                     (cur_len >= TokLenW'(2));

  // Row bookkeeping
  logic [DimBits-1:0] row_next;
  assign row_next = row_q + 1'b1;

  // Next state and the word handed on
  always_comb begin
    phase_d      = phase_q;
    in_comment_d = in_comment_q;
    in_token_d   = in_token_q;
    tok_len_d    = tok_len_q;
    tok_val_d    = tok_val_q;
    tok_bad_d    = tok_bad_q;
    tok_digit_d  = tok_digit_q;
    img_w_d      = img_w_q;
    img_h_d      = img_h_q;
    col_d        = col_q;
    row_last_d   = row_last_q;
    row_d        = row_q;
    push_o       = 1'b0;
    cmd_o.op     = OpError;
    cmd_o.data   = '0;
    cmd_o.code   = ErrMagic;
    cmd_o.last   = 1'b0;
    cmd_o.width  = img_w_q;
    cmd_o.height = img_h_q;

    if (in_hs) begin
      if (in_i.end_of_file) begin
        // close any open token, report what is missing, start over
        if (in_header) begin
          push_o = 1'b1;
          if (!in_token_q) begin
            cmd_o.code = phase_err(phase_q);
          end else if (close_fail) begin
            cmd_o.code = close_code;
          end else if (close_hdr) begin
            cmd_o.op = OpHeaderShort;
          end else begin
            cmd_o.code = phase_err(close_next);
          end
        end else if (phase_q == PhPixels) begin
          push_o     = 1'b1;
          cmd_o.code = ErrShort;
        end
        phase_d      = PhMagic;
        in_comment_d = 1'b0;
        in_token_d   = 1'b0;
        tok_len_d    = '0;
        tok_val_d    = '0;
        tok_bad_d    = 1'b0;
        tok_digit_d  = 1'b0;
        img_w_d      = '0;
        img_h_d      = '0;
        col_d        = '0;
        row_d        = '0;
      end else if (in_header) begin
        if (in_comment_q) begin
          if (b == CharLf) begin
            in_comment_d = 1'b0;
          end
        end else if (is_space(b)) begin
          if (in_token_q) begin
            in_token_d = 1'b0;
            if (close_fail) begin
              push_o     = 1'b1;
              cmd_o.code = close_code;
              phase_d    = PhError;
            end else begin
              phase_d = close_next;
              if (phase_q == PhWidth) begin
                img_w_d = tok_val_q;
              end
              if (phase_q == PhHeight) begin
                img_h_d = tok_val_q;
              end
              if (close_hdr) begin
                push_o     = 1'b1;
                cmd_o.op   = OpHeader;
                col_d      = '0;
                row_d      = '0;
                row_last_d = ColW'({img_w_q, 1'b0}) + ColW'(img_w_q) - 1'b1;
              end
            end
          end
        end else if (!in_token_q && (b == CharHash)) begin
          in_comment_d = 1'b1;
        end else if (too_long) begin
          push_o       = 1'b1;
          cmd_o.code   = ErrTooLong;
          phase_d      = PhError;
          in_token_d   = 1'b0;
          in_comment_d = 1'b0;
        end else begin
          in_token_d  = 1'b1;
          tok_len_d   = cur_len + 1'b1;
          tok_val_d   = cur_val;
          tok_bad_d   = cur_bad;
          tok_digit_d = cur_digit;
          if (phase_q == PhMagic) begin
            tok_bad_d = cur_bad || magic_bad;
          end else if (is_digit) begin
            tok_digit_d = 1'b1;
            if (ovf) begin
              tok_bad_d = 1'b1;
            end else begin
              tok_val_d = prod[DimBits-1:0];
            end
          end else if (!((b == CharPlus) && (cur_len == '0))) begin
            tok_bad_d = 1'b1;
          end
        end
      end else if (phase_q == PhPixels) begin
        push_o     = 1'b1;
        cmd_o.op   = (col_q == '0) ? OpPixelRow : OpPixel;
        cmd_o.data = b;
        if (col_q == row_last_q) begin
          col_d = '0;
          row_d = row_next;
          if (row_next == img_h_q) begin
            cmd_o.last = 1'b1;
            phase_d    = PhDone;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhMagic;
      in_comment_q <= 1'b0;
      in_token_q   <= 1'b0;
      tok_len_q    <= '0;
      tok_val_q    <= '0;
      tok_bad_q    <= 1'b0;
      tok_digit_q  <= 1'b0;
      img_w_q      <= '0;
      img_h_q      <= '0;
      col_q        <= '0;
      row_last_q   <= '0;
      row_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      in_comment_q <= in_comment_d;
      in_token_q   <= in_token_d;
      tok_len_q    <= tok_len_d;
      tok_val_q    <= tok_val_d;
      tok_bad_q    <= tok_bad_d;
      tok_digit_q  <= tok_digit_d;
      img_w_q      <= img_w_d;
      img_h_q      <= img_h_d;
      col_q        <= col_d;
      row_last_q   <= row_last_d;
      row_q        <= row_d;
    end
  end

  // Size limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_w_q <= '1;
      max_h_q <= '1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgMaxWidth:  max_w_q <= cfg_i.data;
        CfgMaxHeight: max_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  `PPMHP_ASSERT(a_eof_restarts, (in_hs && in_i.end_of_file) |=> (phase_q == PhMagic) && !in_token_q && !in_comment_q, "end of file did not restart the parser")
  `PPMHP_NEVER(a_token_in_comment, in_token_q && in_comment_q, "token open inside a comment")

endmodule

// ===== sv/ppmhp_queue.sv =====
`include "ppm_header_parse_row_framer_core_assert.svh"

module ppmhp_queue import ppmhp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic valid_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW + 1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `PPMHP_NEVER(a_no_overflow, push_i && full_o, "word pushed into full queue")
  `PPMHP_NEVER(a_no_underflow, pop_i && !valid_o, "word popped from empty queue")

endmodule

// ===== sv/ppmhp_back.sv =====
`include "ppm_header_parse_row_framer_core_assert.svh"

module ppmhp_back import ppmhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  ppmhp_out_if.source out_o
);

  logic        out_valid_q, out_valid_d;
  logic        sub_q, sub_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [31:0] w_q, w_d;
  logic [31:0] h_q, h_d;
  err_e        code_q, code_d;
  logic        last_q, last_d;

  logic two, load;

  assign two   = (head_i.op == OpPixelRow) || (head_i.op == OpHeaderShort);
  assign load  = head_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = load && (!two || sub_q);

  // Result word for the head entry; second half selected by sub_q
  always_comb begin
    kind_d = KindError;
    byte_d = '0;
    w_d    = '0;
    h_d    = '0;
    code_d = ErrMagic;
    last_d = 1'b0;
    case (head_i.op)
      OpPixel: begin
        kind_d = KindPixel;
        byte_d = head_i.data;
        last_d = head_i.last;
      end
      OpPixelRow: begin
        if (!sub_q) begin
          kind_d = KindFilter;
        end else begin
          kind_d = KindPixel;
          byte_d = head_i.data;
          last_d = head_i.last;
        end
      end
      OpError: begin
        kind_d = KindError;
        code_d = head_i.code;
        last_d = 1'b1;
      end
      OpHeader: begin
        kind_d = KindHeader;
        w_d    = 32'(head_i.width);
        h_d    = 32'(head_i.height);
      end
      OpHeaderShort: begin
        if (!sub_q) begin
          kind_d = KindHeader;
          w_d    = 32'(head_i.width);
          h_d    = 32'(head_i.height);
        end else begin
          kind_d = KindError;
          code_d = ErrShort;
          last_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    if (load) begin
      sub_d       = two && !sub_q;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      w_q    <= w_d;
      h_q    <= h_d;
      code_q <= code_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.width_out  = w_q;
  assign out_o.height_out = h_q;
  assign out_o.error_code = code_q;
  assign out_o.last       = last_q;

  `PPMHP_ASSERT(a_second_half, sub_q |-> head_valid_i && (head_i.op == OpPixelRow || head_i.op == OpHeaderShort), "second result without a two-result entry")

endmodule

// ===== sv/ppm_header_parse_row_framer_core.sv =====
// A word accepted at an edge is parsed into the queue at that same edge; its result then passes
// through the emitter's output register before it shows on out_o.
// Throughput: one input word per cycle while the queue has room; the first pixel of each row and an
// end of file right after the maxval token give two result words each, holding the emitter for both,
// so on short rows, or while out_o is not ready, the 4-entry queue fills and input stalls.
// Reset (rst_ni, asynchronous, active low): parser to magic token, queue and output empty, limits 1s.
module ppm_header_parse_row_framer_core import ppmhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppmhp_in_if.sink    in_i,
  ppmhp_out_if.source out_o,
  ppmhp_cfg_if.sink   cfg_i
);

  logic full, push, pop, head_valid;
  cmd_t cmd, head;

  // Parser: header tokens, comments, row counting
  ppmhp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  // Decoupling queue
  ppmhp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid)
  );

  // Emitter: expands entries into result words
  ppmhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
